>>> hw/rtl/bilinear_stretch_blend_macros.svh
// Assertion macros for the bilinear stretch blend block.
// Used by the top level only; no other dependencies.
`ifndef BILINEAR_STRETCH_BLEND_MACROS_SVH
`define BILINEAR_STRETCH_BLEND_MACROS_SVH
// implication checked every clock outside reset
`define BSB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BSB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> hw/rtl/bsb_pkg.sv
// Shared types and constants for the bilinear stretch blend block.
// No dependencies.
package bsb_pkg;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_A   = 3'd6;
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_BLEND = 1'b1;
	localparam int unsigned ADDR_W = 16;

	typedef struct packed {
		logic        req_type;
		logic [15:0] texel_index;
		logic [31:0] texel_rgba;
		logic [11:0] dest_col;
		logic [11:0] dest_row;
		logic [31:0] dest_rgba;
	} in_req_t;

	typedef struct packed {
		logic [31:0] out_rgba;
		logic [11:0] out_col;
		logic [11:0] out_row;
	} out_res_t;

	// floor(v/255) for v < 65280: q = (v + 1 + (v >> 8)) >> 8
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
		return t[15:8];
	endfunction
endpackage

>>> hw/rtl/bsb_stream_if.sv
// Valid/ready channel for bilinear stretch blend requests and results.
// The payload type is a parameter; the interface itself does not depend on bsb_pkg.
interface bsb_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bilinear_stretch_blend.sv
// Bilinear stretch blend top level: texel memory, coordinate map, filter, blend.
// Depends on bsb_pkg, bsb_stream_if and bilinear_stretch_blend_macros.svh.
// A blend request passes S1 to S9. Throughput: one request per cycle unless stalled;
// the image sits in two memories split by address parity, each read at two addresses
// a cycle, so the four neighbours come in one read.
// Reset: arst_n clears pipeline valids and config registers; the image is undefined.
`include "bilinear_stretch_blend_macros.svh"
module bilinear_stretch_blend #(
	parameter int unsigned MAX_SRC_WIDTH  = 256,
	parameter int unsigned MAX_SRC_HEIGHT = 256,
	parameter int unsigned FRAC_BITS      = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bsb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsb_pkg::CFG_DATA_W-1:0] cfg_data,
	bsb_stream_if.sink                 req,
	bsb_stream_if.source               res
);
	import bsb_pkg::*;

	localparam int unsigned WB = $clog2(MAX_SRC_WIDTH + 1);
	localparam int unsigned HB = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int unsigned F  = FRAC_BITS;
	localparam int unsigned SW = F + 1;
	localparam int unsigned BANK_DEPTH = 1 << (ADDR_W - 1);

	// configuration
	logic [8:0]  src_width_q, src_height_q;
	logic [7:0]  origin_x_q, origin_y_q, galpha_q;
	logic [23:0] step_x_q, step_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 9'd256;
			src_height_q <= 9'd256;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			step_x_q     <= 24'd65536;
			step_y_q     <= 24'd65536;
			galpha_q     <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[8:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[8:0];
				REG_ORIGIN_X:   origin_x_q   <= cfg_data[7:0];
				REG_ORIGIN_Y:   origin_y_q   <= cfg_data[7:0];
				REG_STEP_X:     step_x_q     <= cfg_data;
				REG_STEP_Y:     step_y_q     <= cfg_data;
				REG_GLOBAL_A:   galpha_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// bounded dimensions, minus one
	logic [WB-1:0] wm1;
	logic [HB-1:0] hm1;
	always_comb begin
		if (src_width_q == 9'd0) wm1 = '0;
		else if (32'(src_width_q) > MAX_SRC_WIDTH) wm1 = WB'(MAX_SRC_WIDTH - 1);
		else wm1 = WB'(32'(src_width_q) - 1);
		if (src_height_q == 9'd0) hm1 = '0;
		else if (32'(src_height_q) > MAX_SRC_HEIGHT) hm1 = HB'(MAX_SRC_HEIGHT - 1);
		else hm1 = HB'(32'(src_height_q) - 1);
	end
	logic [WB-1:0] wdim;
	assign wdim = wm1 + WB'(1);

	// pipeline control: every stage advances when the output register frees
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	assign adv = !v_s9 || res.ready;
	assign req.ready = adv;
	logic acc;
	assign acc = req.valid && adv;

	// S1: register request
	in_req_t r_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= acc;
	end
	always_ff @(posedge clk) if (adv) r_s1 <= req.data;

	// S2: coordinate multiply
	logic [36:0] cx_s2, cy_s2;
	logic        ld_s2;
	logic [15:0] lidx_s2;
	logic [31:0] ltex_s2, dst_s2;
	logic [11:0] col_s2, row_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) if (adv) begin
		cx_s2 <= {13'd0, origin_x_q, 16'd0} + 37'(r_s1.dest_col) * 37'(step_x_q);
		cy_s2 <= {13'd0, origin_y_q, 16'd0} + 37'(r_s1.dest_row) * 37'(step_y_q);
		ld_s2   <= r_s1.req_type == REQ_LOAD;
		lidx_s2 <= r_s1.texel_index;
		ltex_s2 <= r_s1.texel_rgba;
		dst_s2  <= r_s1.dest_rgba;
		col_s2  <= r_s1.dest_col;
		row_s2  <= r_s1.dest_row;
	end

	// S3: clamp coordinates
	logic [20:0] ix, iy;
	assign ix = cx_s2[36:16];
	assign iy = cy_s2[36:16];
	logic [WB-1:0] x0_s3, x1_s3;
	logic [HB-1:0] y0_s3, y1_s3;
	logic [F-1:0]  fx_s3, fy_s3;
	logic          ld_s3;
	logic [15:0]   lidx_s3;
	logic [31:0]   ltex_s3, dst_s3;
	logic [11:0]   col_s3, row_s3;
	logic [WB-1:0] x0c;
	logic [HB-1:0] y0c;
	always_comb begin
		x0c = (ix > 21'(wm1)) ? wm1 : WB'(ix);
		y0c = (iy > 21'(hm1)) ? hm1 : HB'(iy);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) if (adv) begin
		x0_s3 <= x0c;
		y0_s3 <= y0c;
		x1_s3 <= (x0c == wm1) ? wm1 : x0c + WB'(1);
		y1_s3 <= (y0c == hm1) ? hm1 : y0c + HB'(1);
		fx_s3 <= cx_s2[15:16-F];
		fy_s3 <= cy_s2[15:16-F];
		ld_s3 <= ld_s2; lidx_s3 <= lidx_s2; ltex_s3 <= ltex_s2;
		dst_s3 <= dst_s2; col_s3 <= col_s2; row_s3 <= row_s2;
	end

	// S4: addresses row*width+col
	logic [ADDR_W-1:0] a00_s4, a01_s4, a10_s4, a11_s4;
	logic [F-1:0]  fx_s4, fy_s4;
	logic          ld_s4;
	logic [15:0]   lidx_s4;
	logic [31:0]   ltex_s4, dst_s4;
	logic [11:0]   col_s4, row_s4;
	logic [ADDR_W-1:0] rb0, rb1;
	assign rb0 = ADDR_W'(32'(y0_s3) * 32'(wdim));
	assign rb1 = ADDR_W'(32'(y1_s3) * 32'(wdim));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) if (adv) begin
		a00_s4 <= rb0 + ADDR_W'(x0_s3);
		a01_s4 <= rb0 + ADDR_W'(x1_s3);
		a10_s4 <= rb1 + ADDR_W'(x0_s3);
		a11_s4 <= rb1 + ADDR_W'(x1_s3);
		fx_s4 <= fx_s3; fy_s4 <= fy_s3;
		ld_s4 <= ld_s3; lidx_s4 <= lidx_s3; ltex_s4 <= ltex_s3;
		dst_s4 <= dst_s3; col_s4 <= col_s3; row_s4 <= row_s3;
	end

	// Memory: even and odd addresses in separate memories. Left and right
	// neighbours of a row sit at a and a+1 (or both at a when clamped), so each
	// row pair hits each memory at most once; two rows give two reads per memory.
	// A load writes in S4; a later blend reaches S4 only in a later cycle.
	logic [31:0] mem_even [BANK_DEPTH];
	logic [31:0] mem_odd  [BANK_DEPTH];
	logic [ADDR_W-2:0] ev_top, od_top, ev_bot, od_bot;
	always_comb begin
		ev_top = a00_s4[0] ? a01_s4[ADDR_W-1:1] : a00_s4[ADDR_W-1:1];
		od_top = a00_s4[0] ? a00_s4[ADDR_W-1:1] : a01_s4[ADDR_W-1:1];
		ev_bot = a10_s4[0] ? a11_s4[ADDR_W-1:1] : a10_s4[ADDR_W-1:1];
		od_bot = a10_s4[0] ? a10_s4[ADDR_W-1:1] : a11_s4[ADDR_W-1:1];
	end
	logic [31:0] ev_top_s5, od_top_s5, ev_bot_s5, od_bot_s5;
	logic        wr;
	assign wr = adv && v_s4 && ld_s4;
	always_ff @(posedge clk) begin
		if (wr && !lidx_s4[0]) mem_even[lidx_s4[ADDR_W-1:1]] <= ltex_s4;
		if (adv) begin
			ev_top_s5 <= mem_even[ev_top];
			ev_bot_s5 <= mem_even[ev_bot];
		end
	end
	always_ff @(posedge clk) begin
		if (wr && lidx_s4[0]) mem_odd[lidx_s4[ADDR_W-1:1]] <= ltex_s4;
		if (adv) begin
			od_top_s5 <= mem_odd[od_top];
			od_bot_s5 <= mem_odd[od_bot];
		end
	end
	logic [3:0]   par_s5;  // address parity of tl, tr, bl, br
	logic [F-1:0] fx_s5, fy_s5;
	logic         ld_s5;
	logic [31:0]  dst_s5;
	logic [11:0]  col_s5, row_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) if (adv) begin
		par_s5 <= {a11_s4[0], a10_s4[0], a01_s4[0], a00_s4[0]};
		fx_s5 <= fx_s4; fy_s5 <= fy_s4; ld_s5 <= ld_s4;
		dst_s5 <= dst_s4; col_s5 <= col_s4; row_s5 <= row_s4;
	end
	logic [31:0] tl_d, tr_d, bl_d, br_d;
	assign tl_d = par_s5[0] ? od_top_s5 : ev_top_s5;
	assign tr_d = par_s5[1] ? od_top_s5 : ev_top_s5;
	assign bl_d = par_s5[2] ? od_bot_s5 : ev_bot_s5;
	assign br_d = par_s5[3] ? od_bot_s5 : ev_bot_s5;

	// S6: vertical pass per channel: left/right sums, 8 x 17 bits
	logic [SW-1:0] sfy;
	assign sfy = SW'(1 << F) - SW'(fy_s5);
	logic [8+SW-1:0] lft_s6 [4];
	logic [8+SW-1:0] rgt_s6 [4];
	logic [F-1:0]    fx_s6;
	logic            ld_s6;
	logic [31:0]     dst_s6;
	logic [11:0]     col_s6, row_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) if (adv) begin
		for (int k = 0; k < 4; k++) begin
			lft_s6[k] <= (8+SW)'(tl_d[8*k +: 8]) * (8+SW)'(sfy)
				+ (8+SW)'(bl_d[8*k +: 8]) * (8+SW)'(fy_s5);
			rgt_s6[k] <= (8+SW)'(tr_d[8*k +: 8]) * (8+SW)'(sfy)
				+ (8+SW)'(br_d[8*k +: 8]) * (8+SW)'(fy_s5);
		end
		fx_s6 <= fx_s5; ld_s6 <= ld_s5;
		dst_s6 <= dst_s5; col_s6 <= col_s5; row_s6 <= row_s5;
	end

	// S7: horizontal pass, truncated texel; loads drop out here
	logic [SW-1:0] sfx;
	assign sfx = SW'(1 << F) - SW'(fx_s6);
	logic [2*SW+7:0] hv [4];
	logic [7:0]  sc_s7 [4];
	logic [31:0] dst_s7;
	logic [11:0] col_s7, row_s7;
	always_comb begin
		for (int k = 0; k < 4; k++)
			hv[k] = (2*SW+8)'(lft_s6[k]) * (2*SW+8)'(sfx)
				+ (2*SW+8)'(rgt_s6[k]) * (2*SW+8)'(fx_s6);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6 && !ld_s6;
	end
	always_ff @(posedge clk) if (adv) begin
		for (int k = 0; k < 4; k++)
			sc_s7[k] <= hv[k][2*F +: 8];
		dst_s7 <= dst_s6; col_s7 <= col_s6; row_s7 <= row_s6;
	end

	// S8: effective source alpha
	logic [7:0]  a0_s8;
	logic [7:0]  sc_s8 [3];
	logic [31:0] dst_s8;
	logic [11:0] col_s8, row_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= v_s7;
	end
	always_ff @(posedge clk) if (adv) begin
		a0_s8 <= div255(16'(sc_s7[3]) * 16'(galpha_q));
		for (int k = 0; k < 3; k++)
			sc_s8[k] <= sc_s7[k];
		dst_s8 <= dst_s7; col_s8 <= col_s7; row_s8 <= row_s7;
	end

	// S9: blend and output register
	logic [7:0] a1;
	out_res_t out_d;
	always_comb begin
		a1 = 8'd255 - a0_s8;
		for (int k = 0; k < 3; k++)
			out_d.out_rgba[8*k +: 8] = div255(16'(sc_s8[k]) * 16'(a0_s8)
				+ 16'(dst_s8[8*k +: 8]) * 16'(a1));
		out_d.out_rgba[31:24] = a0_s8 + div255(16'(dst_s8[31:24]) * 16'(a1));
		out_d.out_col = col_s8;
		out_d.out_row = row_s8;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (adv) v_s9 <= v_s8;
	end
	always_ff @(posedge clk) if (adv) res.data <= out_d;
	assign res.valid = v_s9;

	`BSB_ASSERT_NXT(a_hold, res.valid && !res.ready, res.valid && $stable(res.data), "result dropped")
	`BSB_ASSERT_IMP(a_ready, req.ready, !res.valid || res.ready, "ready while output stalled")
	`BSB_ASSERT_NXT(a_load_nores, adv && v_s6 && ld_s6, !v_s7, "load produced a result")
endmodule
